[rtl/htw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_pkg
// shared types and constants for the hashed timer wheel
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int unsigned TimerIdxW  = 5;
  localparam int unsigned DelayW     = 32;
  localparam int unsigned TickW      = 64;
  localparam int unsigned MaxResults = 32;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SET_UNLINK,
    ST_SET_APP_RD,
    ST_SET_APPEND,
    ST_SET_ACK,
    ST_TICK_LOAD,
    ST_TICK_WALK,
    ST_TICK_DONE
  } htw_state_t;

  typedef struct packed {
    logic init_step;
    logic load_item;
    logic decode;
    logic set_unlink;
    logic app_read;
    logic set_append;
    logic set_ack;
    logic tick_load;
    logic node_unlink;
    logic node_skip;
    logic tick_done;
  } htw_cmd_t;

  typedef struct packed {
    logic init_done;
    logic op_tick;
    logic in_pool;
    logic was_armed;
    logic arm;
    logic cur_nil;
    logic cur_due;
    logic count_full;
  } htw_status_t;

endpackage

[rtl/hashed_timer_wheel_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_timer_wheel_unit
// hashed timing wheel for a fixed pool of timers
// ----------------------------------------------------------------------------
// One item at a time. WHEEL_SIZE must be a power of two and NUM_TIMERS at
// most 32. After reset the bucket memory is cleared, one bucket per cycle,
// with busy high. After the accepting edge a set-timeout keeps busy high
// through decode, unlink when armed, bucket read and append when the delay
// is nonzero, and acknowledge; a tick keeps it high through bucket load, the
// walk of the bucket, one node per cycle, and done. The last result of an
// item appears in the cycle in which busy falls. Results appear with strobe
// for one cycle each and cannot be held off; last marks the final result of
// an item.
module hashed_timer_wheel_unit #(
  parameter int unsigned WHEEL_SIZE = 128,
  parameter int unsigned NUM_TIMERS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [htw_pkg::TimerIdxW-1:0] timer_index,
  input  logic [htw_pkg::DelayW-1:0]    delay_ticks,
  output logic                          strobe,
  output logic                          fired,
  output logic [htw_pkg::TimerIdxW-1:0] expired_timer,
  output logic                          was_armed,
  output logic                          last
);
  import htw_pkg::*;

  htw_cmd_t    cmd;
  htw_status_t sts;

  htw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  htw_dp #(
    .WHEEL_SIZE (WHEEL_SIZE),
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .operation     (operation),
    .timer_index   (timer_index),
    .delay_ticks   (delay_ticks),
    .sts           (sts),
    .strobe        (strobe),
    .fired         (fired),
    .expired_timer (expired_timer),
    .was_armed     (was_armed),
    .last          (last)
  );

endmodule

[rtl/htw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_ctrl
// sequencer for set-timeout and tick items
// ----------------------------------------------------------------------------
module htw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  htw_pkg::htw_status_t sts,
  output logic                 busy,
  output htw_pkg::htw_cmd_t    cmd
);
  import htw_pkg::*;

  htw_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:       if (sts.init_done) state_next = ST_IDLE;
      ST_IDLE:       if (start) state_next = ST_DECODE;
      ST_DECODE: begin
        if (sts.op_tick) state_next = ST_TICK_LOAD;
        else if (!sts.in_pool) state_next = ST_SET_ACK;
        else if (sts.was_armed) state_next = ST_SET_UNLINK;
        else if (sts.arm) state_next = ST_SET_APP_RD;
        else state_next = ST_SET_ACK;
      end
      ST_SET_UNLINK: state_next = sts.arm ? ST_SET_APP_RD : ST_SET_ACK;
      ST_SET_APP_RD: state_next = ST_SET_APPEND;
      ST_SET_APPEND: state_next = ST_SET_ACK;
      ST_SET_ACK:    state_next = ST_IDLE;
      ST_TICK_LOAD:  state_next = ST_TICK_WALK;
      ST_TICK_WALK: begin
        if (sts.cur_nil || sts.count_full) state_next = ST_TICK_DONE;
      end
      ST_TICK_DONE:  state_next = ST_IDLE;
      default:       state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_INIT:       cmd.init_step = 1'b1;
      ST_IDLE:       cmd.load_item = start;
      ST_DECODE:     cmd.decode = 1'b1;
      ST_SET_UNLINK: cmd.set_unlink = 1'b1;
      ST_SET_APP_RD: cmd.app_read = 1'b1;
      ST_SET_APPEND: cmd.set_append = 1'b1;
      ST_SET_ACK:    cmd.set_ack = 1'b1;
      ST_TICK_LOAD:  cmd.tick_load = 1'b1;
      ST_TICK_WALK: begin
        if (!sts.cur_nil && !sts.count_full) begin
          cmd.node_unlink = sts.cur_due;
          cmd.node_skip   = !sts.cur_due;
        end
      end
      ST_TICK_DONE:  cmd.tick_done = 1'b1;
      default:       cmd = '0;
    endcase
  end

endmodule

[rtl/htw_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_dp
// timer records, bucket lists and tick counter
// ----------------------------------------------------------------------------
module htw_dp #(
  parameter int unsigned WHEEL_SIZE = 128,
  parameter int unsigned NUM_TIMERS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  htw_pkg::htw_cmd_t                cmd,
  input  logic                             operation,
  input  logic [htw_pkg::TimerIdxW-1:0]    timer_index,
  input  logic [htw_pkg::DelayW-1:0]       delay_ticks,
  output htw_pkg::htw_status_t             sts,
  output logic                             strobe,
  output logic                             fired,
  output logic [htw_pkg::TimerIdxW-1:0]    expired_timer,
  output logic                             was_armed,
  output logic                             last
);
  import htw_pkg::*;

  localparam int unsigned BW  = (WHEEL_SIZE > 1) ? $clog2(WHEEL_SIZE) : 1;
  localparam int unsigned LW  = $clog2(NUM_TIMERS + 1);
  localparam int unsigned TW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [LW-1:0] NIL = LW'(NUM_TIMERS);
  localparam int unsigned CW  = $clog2(MaxResults + 1);

  // bucket memory: {head, tail}
  logic [2*LW-1:0] bkt_mem [WHEEL_SIZE];
  logic [BW-1:0]   bkt_waddr;
  logic [2*LW-1:0] bkt_wdata;
  logic            bkt_we;
  logic [BW-1:0]   bkt_raddr;
  logic [2*LW-1:0] bkt_rdata;

  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
    bkt_rdata <= bkt_mem[bkt_raddr];
  end

  logic [NUM_TIMERS-1:0] armed;
  logic [TickW-1:0]      expiry [NUM_TIMERS];
  logic [LW-1:0]         nxt    [NUM_TIMERS];
  logic [LW-1:0]         prv    [NUM_TIMERS];

  logic [TickW-1:0]     now_ticks;
  logic [BW:0]          init_cnt;
  logic                 op_r;
  logic [TimerIdxW-1:0] idx_r;
  logic [DelayW-1:0]    delay_r;
  logic                 was_r;
  logic [LW-1:0]        cur;
  logic [CW-1:0]        count;
  logic [LW-1:0]        head_r, tail_r;
  logic                 pend;
  logic [TimerIdxW-1:0] pend_idx;

  logic [TW-1:0]    idx_t;
  logic [LW-1:0]    idx_l;
  logic [TW-1:0]    t_sel;
  logic [TickW-1:0] t_exp;
  logic [TickW-1:0] new_exp;
  logic [LW-1:0]    p_l, n_l;
  logic [BW-1:0]    b_old, b_now, b_new;
  logic [LW-1:0]    rd_head, rd_tail;
  logic [LW-1:0]    base_head, base_tail;
  logic [LW-1:0]    unl_head, unl_tail;
  logic             init_done;
  logic             in_pool;

  assign idx_t     = idx_r[TW-1:0];
  assign idx_l     = LW'(idx_t);
  assign t_sel     = op_r ? cur[TW-1:0] : idx_t;
  assign t_exp     = expiry[t_sel];
  assign new_exp   = now_ticks + TickW'(delay_r) + TickW'(1);
  assign p_l       = prv[t_sel];
  assign n_l       = nxt[t_sel];
  assign b_old     = t_exp[BW-1:0];
  assign b_now     = now_ticks[BW-1:0];
  assign b_new     = new_exp[BW-1:0];
  assign rd_head   = bkt_rdata[2*LW-1:LW];
  assign rd_tail   = bkt_rdata[LW-1:0];
  assign base_head = op_r ? head_r : rd_head;
  assign base_tail = op_r ? tail_r : rd_tail;
  assign unl_head  = (p_l == NIL) ? n_l : base_head;
  assign unl_tail  = (n_l == NIL) ? p_l : base_tail;
  assign init_done = (init_cnt == (BW+1)'(WHEEL_SIZE));
  assign in_pool   = ({1'b0, idx_r} < (TimerIdxW+1)'(NUM_TIMERS));

  assign sts.init_done  = init_done;
  assign sts.op_tick    = (op_r == OP_TICK);
  assign sts.in_pool    = in_pool;
  assign sts.was_armed  = in_pool && armed[idx_t];
  assign sts.arm        = (delay_r != '0);
  assign sts.cur_nil    = (cur == NIL);
  assign sts.cur_due    = (cur != NIL) && (t_exp <= now_ticks);
  assign sts.count_full = (count == CW'(MaxResults));

  assign bkt_raddr = cmd.app_read ? b_new : (op_r ? b_now : b_old);

  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = b_now;
    bkt_wdata = {unl_head, unl_tail};
    if (cmd.init_step) begin
      bkt_we    = !init_done;
      bkt_waddr = init_cnt[BW-1:0];
      bkt_wdata = {NIL, NIL};
    end else if (cmd.set_unlink) begin
      bkt_we    = 1'b1;
      bkt_waddr = b_old;
    end else if (cmd.set_append) begin
      bkt_we    = 1'b1;
      bkt_waddr = b_new;
      bkt_wdata = {(rd_tail == NIL) ? idx_l : rd_head, idx_l};
    end else if (cmd.node_unlink) begin
      bkt_we    = 1'b1;
      bkt_waddr = b_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt <= '0;
      now_ticks <= '0;
      armed <= '0;
      strobe <= 1'b0;
      pend <= 1'b0;
      fired <= 1'b0;
      expired_timer <= '0;
      was_armed <= 1'b0;
      last <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.init_step && !init_done) init_cnt <= init_cnt + 1'b1;
      if (cmd.load_item) begin
        op_r <= operation;
        idx_r <= timer_index;
        delay_r <= delay_ticks;
        count <= '0;
        pend <= 1'b0;
      end
      if (cmd.decode) was_r <= sts.was_armed;
      if (cmd.set_unlink || cmd.node_unlink) begin
        if (p_l != NIL) nxt[p_l[TW-1:0]] <= n_l;
        if (n_l != NIL) prv[n_l[TW-1:0]] <= p_l;
        armed[t_sel] <= 1'b0;
      end
      if (cmd.set_append) begin
        expiry[idx_t] <= new_exp;
        prv[idx_t] <= rd_tail;
        nxt[idx_t] <= NIL;
        if (rd_tail != NIL) nxt[rd_tail[TW-1:0]] <= idx_l;
        armed[idx_t] <= 1'b1;
      end
      if (cmd.set_ack) begin
        strobe <= 1'b1;
        fired <= 1'b0;
        expired_timer <= '0;
        was_armed <= was_r;
        last <= 1'b1;
      end
      if (cmd.tick_load) begin
        cur <= rd_head;
        head_r <= rd_head;
        tail_r <= rd_tail;
      end
      if (cmd.node_unlink) begin
        if (pend) begin
          strobe <= 1'b1;
          fired <= 1'b1;
          expired_timer <= pend_idx;
          was_armed <= 1'b0;
          last <= 1'b0;
        end
        pend <= 1'b1;
        pend_idx <= TimerIdxW'(cur[TW-1:0]);
        count <= count + 1'b1;
        head_r <= unl_head;
        tail_r <= unl_tail;
        cur <= n_l;
      end
      if (cmd.node_skip) cur <= n_l;
      if (cmd.tick_done) begin
        strobe <= 1'b1;
        fired <= pend;
        expired_timer <= pend ? pend_idx : '0;
        was_armed <= 1'b0;
        last <= 1'b1;
        pend <= 1'b0;
        now_ticks <= now_ticks + 1'b1;
      end
    end
  end

endmodule

[verif/hashed_timer_wheel_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_timer_wheel_unit_test
// self-checking bench for the hashed timer wheel: a behavioral wheel model
// predicts the acknowledgements and expirations of every accepted item, and
// a checker compares each strobed result in order, field by field
// ----------------------------------------------------------------------------
module hashed_timer_wheel_unit_test;
  import htw_pkg::*;

  localparam int Wheel = 128;
  localparam int Timers = 32;
  localparam logic [7:0] NoLink = 8'hFF;
  localparam int IdleLimit = 5000;

  typedef struct packed {
    logic                 fired;
    logic [TimerIdxW-1:0] expired_timer;
    logic                 was_armed;
    logic                 last;
  } wheel_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 operation = OP_SET;
  logic [TimerIdxW-1:0] timer_index = '0;
  logic [DelayW-1:0]    delay_ticks = '0;
  logic                 strobe;
  logic                 fired;
  logic [TimerIdxW-1:0] expired_timer;
  logic                 was_armed;
  logic                 last;

  // wheel model state
  logic [TickW-1:0] wheel_now;
  logic             armed_q [Timers];
  logic [TickW-1:0] expiry_q [Timers];
  logic [7:0]       next_q [Timers];
  logic [7:0]       prev_q [Timers];
  logic [7:0]       head_q [Wheel];
  logic [7:0]       tail_q [Wheel];

  wheel_result_t pending_results[$];
  int failures = 0;
  int items_sent = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int fires_seen = 0;
  int idle_cycles = 0;
  int gap_pct = 0;

  hashed_timer_wheel_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .timer_index(timer_index), .delay_ticks(delay_ticks),
    .strobe(strobe), .fired(fired), .expired_timer(expired_timer),
    .was_armed(was_armed), .last(last)
  );

  always #4 clk = ~clk;

  function automatic int bucket_of(logic [TickW-1:0] t);
    return int'(t % Wheel);
  endfunction

  task automatic wheel_clear();
    wheel_now = '0;
    for (int i = 0; i < Timers; i++) begin
      armed_q[i] = 1'b0;
      next_q[i] = NoLink;
      prev_q[i] = NoLink;
      expiry_q[i] = '0;
    end
    for (int b = 0; b < Wheel; b++) begin
      head_q[b] = NoLink;
      tail_q[b] = NoLink;
    end
  endtask

  task automatic wheel_unlink(int t);
    int b;
    logic [7:0] p, n;
    b = bucket_of(expiry_q[t]);
    p = prev_q[t];
    n = next_q[t];
    if (p == NoLink) head_q[b] = n;
    else next_q[p] = n;
    if (n == NoLink) tail_q[b] = p;
    else prev_q[n] = p;
    armed_q[t] = 1'b0;
  endtask

  task automatic wheel_append(int t);
    int b;
    logic [7:0] tl;
    b = bucket_of(expiry_q[t]);
    tl = tail_q[b];
    prev_q[t] = tl;
    next_q[t] = NoLink;
    if (tl == NoLink) head_q[b] = 8'(t);
    else next_q[tl] = 8'(t);
    tail_q[b] = 8'(t);
    armed_q[t] = 1'b1;
  endtask

  task automatic predict_wheel_item(logic op, logic [TimerIdxW-1:0] idx,
                                    logic [DelayW-1:0] dly);
    wheel_result_t r;
    logic [7:0] cur, nxt;
    int count;
    int b;
    r = '0;
    if (op == OP_SET) begin
      if (int'(idx) < Timers) begin
        if (armed_q[idx]) begin
          r.was_armed = 1'b1;
          wheel_unlink(idx);
        end
        if (dly != 0) begin
          expiry_q[idx] = wheel_now + TickW'(dly) + 1;
          wheel_append(idx);
        end
      end
      r.last = 1'b1;
      pending_results.push_back(r);
    end else begin
      b = bucket_of(wheel_now);
      cur = head_q[b];
      count = 0;
      while (cur != NoLink && cur < Timers && count < MaxResults) begin
        nxt = next_q[cur];
        if (expiry_q[cur] <= wheel_now) begin
          wheel_unlink(cur);
          r = '0;
          r.fired = 1'b1;
          r.expired_timer = cur[TimerIdxW-1:0];
          pending_results.push_back(r);
          count++;
        end
        cur = nxt;
      end
      if (count == 0) begin
        r = '0;
        r.last = 1'b1;
        pending_results.push_back(r);
      end else begin
        r = pending_results.pop_back();
        r.last = 1'b1;
        pending_results.push_back(r);
      end
      wheel_now = wheel_now + 1;
    end
  endtask

  // called at a rising edge; returns at the edge that accepts the item, or after a random gap with start low
  task automatic send_item(logic op, logic [TimerIdxW-1:0] idx, logic [DelayW-1:0] dly);
    int gap;
    operation <= op;
    timer_index <= idx;
    delay_ticks <= dly;
    start <= 1'b1;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    predict_wheel_item(op, idx, dly);
    items_sent++;
    if (op == OP_TICK) ticks_sent++;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_set(int idx, logic [DelayW-1:0] dly);
    send_item(OP_SET, TimerIdxW'(idx), dly);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, TimerIdxW'($urandom), DelayW'($urandom));
  endtask

  // result checker
  always @(negedge clk) begin
    wheel_result_t exp_r;
    if (!rst && strobe) begin
      results_seen++;
      if (fired) fires_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result fired=%0d timer=%0d", fired, expired_timer);
        failures++;
      end else begin
        exp_r = pending_results.pop_front();
        if (fired !== exp_r.fired) begin
          $error("fired expected %0d actual %0d", exp_r.fired, fired);
          failures++;
        end
        if (expired_timer !== exp_r.expired_timer) begin
          $error("expired_timer expected %0d actual %0d", exp_r.expired_timer,
                 expired_timer);
          failures++;
        end
        if (was_armed !== exp_r.was_armed) begin
          $error("was_armed expected %0d actual %0d", exp_r.was_armed, was_armed);
          failures++;
        end
        if (last !== exp_r.last) begin
          $error("last expected %0d actual %0d", exp_r.last, last);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired, %0d results outstanding", pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_set_extremes();
    send_tick();
    send_set(0, 32'd1);
    send_set(31, 32'hFFFF_FFFF);
    send_set(31, 32'd0);
    send_set(31, 32'd0);
    send_set(0, 32'd3);
    send_set(17, 32'hAAAA_AAAA);
    send_set(10, 32'h5555_5555);
    send_set(17, 32'd0);
    send_set(10, 32'd0);
    repeat (6) send_tick();
  endtask

  task automatic test_bucket_order();
    // same bucket, one lap apart, then a refresh moves a timer to another bucket
    send_set(4, 32'd2);
    send_set(5, 32'd130);
    send_set(6, 32'd2);
    send_set(4, 32'd1);
    repeat (4) send_tick();
  endtask

  task automatic test_full_bucket();
    for (int i = 0; i < Timers; i++) send_set(i, 32'd1);
    repeat (3) send_tick();
  endtask

  task automatic test_random(int n, int pct);
    int sel;
    gap_pct = pct;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 45) send_tick();
      else if (sel < 55) send_set($urandom_range(Timers - 1), 32'd0);
      else if (sel < 60) send_set($urandom_range(Timers - 1), DelayW'($urandom));
      else if (sel < 75) send_set($urandom_range(Timers - 1), DelayW'($urandom_range(1, 8)));
      else send_set($urandom_range(Timers - 1), DelayW'($urandom_range(1, 300)));
    end
  endtask

  initial begin
    wheel_clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_set_extremes();
    test_bucket_order();
    test_full_bucket();
    test_random(140, 11);
    test_random(140, 85);
    test_random(140, 0);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d items (%0d ticks), checked %0d results, %0d expirations",
             items_sent, ticks_sent, results_seen, fires_seen);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[hashed_timer_wheel_unit.f]
rtl/htw_pkg.sv
rtl/htw_ctrl.sv
rtl/htw_dp.sv
rtl/hashed_timer_wheel_unit.sv
verif/hashed_timer_wheel_unit_test.sv
